// ----- hdl/ifp_pkg.sv -----
// Shared types, codes and operator tables for the infix-to-postfix converter.
// No dependencies; imported by ifp_cell and infix_to_postfix_converter_top.
package ifp_pkg;

    localparam int STACK_DEPTH_DEF  = 32;
    localparam int PAYLOAD_BITS_DEF = 16;

    // Input token kinds
    localparam logic [2:0] TK_OPERAND = 3'd0;
    localparam logic [2:0] TK_LPAREN  = 3'd1;
    localparam logic [2:0] TK_RPAREN  = 3'd2;
    localparam logic [2:0] TK_OPER    = 3'd3;
    localparam logic [2:0] TK_END     = 3'd4;

    // Result kinds
    localparam logic [1:0] RK_OPERAND = 2'd0;
    localparam logic [1:0] RK_OPER    = 2'd1;
    localparam logic [1:0] RK_END     = 2'd2;
    localparam logic [1:0] RK_ERROR   = 2'd3;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LAST    = 4'd8;

    // Shift command for the stack cells
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP
    } shift_cmd_t;

    // Precedence by op code; codes above the table wrap modulo nine
    function automatic logic [4:0] op_prec(input logic [3:0] op);
        logic [4:0] p;
        case (op)
            4'd0, 4'd1, 4'd9, 4'd10:  p = 5'd1;
            4'd2, 4'd3, 4'd11, 4'd12: p = 5'd5;
            4'd4, 4'd13:              p = 5'd15;
            4'd5, 4'd6, 4'd14, 4'd15: p = 5'd10;
            default:                  p = 5'd20;
        endcase
        return p;
    endfunction

    function automatic logic op_left_assoc(input logic [3:0] op);
        return (op <= 4'd3);
    endfunction

    // True when a stacked operator leaves before the incoming one is pushed
    function automatic logic op_pops(input logic [3:0] top_op, input logic [3:0] in_op);
        logic [4:0] tp;
        logic [4:0] ip;
        tp = op_prec(top_op);
        ip = op_prec(in_op);
        return (tp > ip) || ((tp == ip) && op_left_assoc(in_op));
    endfunction

endpackage

// ----- hdl/infix_to_postfix_converter_top.sv -----
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on ifp_pkg and ifp_cell (one cell per stack entry).
//
// Usage:
//   Infix tokens arrive on the s_ channel (s_valid/s_ready); postfix results
//   leave on the m_ channel (m_valid/m_ready), one transfer per result, with
//   m_last marking the final result of each input token. A token is taken
//   only while the converter is idle; after the transfer it does its stack
//   actions (pop, push, discard or emit) in turn. An operand is held in the
//   token register and then loaded into the output register, after which
//   the next token can follow. An operator token pops the operators that
//   leave before it and then pushes; a right paren pops down to its matching
//   left paren and drops it, or empties the stack if there is none; the end
//   token pops every entry, dropping left parens, then emits its end result.
//   Every operator is pushed and popped at most once.
//   The stack is a chain of shifting cells with the top in cell 0, so a
//   push or pop moves every entry one place at once; one stack action per
//   cycle is done while the output register can take a result.
//   A single output register parts the channels: a new token is accepted
//   while the last result still waits for m_ready. While the receiver
//   stalls, pending pops hold and nothing is lost.
//   Reset (aresetn low, synchronous) empties the stack and drops any result
//   in flight; stack cell contents are not cleared and need not be.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH  = ifp_pkg::STACK_DEPTH_DEF,
    parameter int PAYLOAD_BITS = ifp_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_token_kind,
    input  logic [3:0]              s_op_code,
    input  logic [PAYLOAD_BITS-1:0] s_payload,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_out_kind,
    output logic [3:0]              m_out_op_code,
    output logic [PAYLOAD_BITS-1:0] m_out_payload,
    output logic                    m_last
);
    import ifp_pkg::*;

    localparam int EW = PAYLOAD_BITS + 5;            // {lparen, op[3:0], payload}
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [2:0]              tok_kind_reg, tok_kind_next;
    logic [3:0]              tok_op_reg, tok_op_next;
    logic [PAYLOAD_BITS-1:0] tok_pay_reg, tok_pay_next;

    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              m_kind_reg, m_kind_next;
    logic [3:0]              m_op_reg, m_op_next;
    logic [PAYLOAD_BITS-1:0] m_pay_reg, m_pay_next;
    logic                    m_last_reg, m_last_next;

    shift_cmd_t              cmd;
    logic [EW-1:0]           push_entry;
    logic [EW-1:0]           cell_q [STACK_DEPTH];

    // Top two stack entries, cell 0 is the top
    logic                    top_lpar, sec_lpar;
    logic [3:0]              top_op, sec_op;
    logic [PAYLOAD_BITS-1:0] top_pay;
    logic                    out_free;
    logic                    has_top, has_sec, full;

    assign top_lpar = cell_q[0][EW-1];
    assign top_op   = cell_q[0][EW-2 -: 4];
    assign top_pay  = cell_q[0][PAYLOAD_BITS-1:0];
    assign sec_lpar = cell_q[1][EW-1];
    assign sec_op   = cell_q[1][EW-2 -: 4];

    assign has_top  = (cnt_reg != '0);
    assign has_sec  = (cnt_reg > CW'(1));
    assign full     = (cnt_reg == CW'(STACK_DEPTH));
    assign out_free = !m_valid_reg || m_ready;

    // Stack chain: push shifts entries down from cell 0, pop shifts them up
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [EW-1:0] above;
        logic [EW-1:0] below;
        if (i == 0) begin : g_head
            assign above = push_entry;
        end else begin : g_mid
            assign above = cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_tail
            assign below = cell_q[i];
        end else begin : g_body
            assign below = cell_q[i+1];
        end
        ifp_cell #(
            .ENTRY_BITS (EW)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .entry      (cell_q[i])
        );
    end

    always_comb begin
        logic       emit;
        logic [1:0] e_kind;
        logic [3:0] e_op;
        logic [PAYLOAD_BITS-1:0] e_pay;
        logic       e_last;
        logic       done;

        emit   = 1'b0;
        e_kind = RK_OPERAND;
        e_op   = OP_NONE;
        e_pay  = '0;
        e_last = 1'b0;
        done   = 1'b0;
        cmd    = SH_HOLD;

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        tok_kind_next = tok_kind_reg;
        tok_op_next   = tok_op_reg;
        tok_pay_next  = tok_pay_reg;

        if (tok_kind_reg == TK_LPAREN) begin
            push_entry = {1'b1, OP_NONE, tok_pay_reg};
        end else begin
            push_entry = {1'b0, tok_op_reg, tok_pay_reg};
        end

        unique case (state_reg)
            ST_IDLE: begin
                // Latch the token on transfer
                if (s_valid) begin
                    tok_kind_next = s_token_kind;
                    tok_op_next   = s_op_code;
                    tok_pay_next  = s_payload;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    case (tok_kind_reg)
                        TK_OPERAND: begin
                            emit   = 1'b1;
                            e_kind = RK_OPERAND;
                            e_pay  = tok_pay_reg;
                            e_last = 1'b1;
                            done   = 1'b1;
                        end
                        TK_LPAREN: begin
                            if (full) begin
                                emit     = 1'b1;
                                e_kind   = RK_ERROR;
                                e_last   = 1'b1;
                                cnt_next = '0;
                            end else begin
                                cmd      = SH_PUSH;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            done = 1'b1;
                        end
                        TK_RPAREN: begin
                            if (has_top && !top_lpar) begin
                                // Pop an operator; its result is last unless the next one goes too
                                emit     = 1'b1;
                                e_kind   = RK_OPER;
                                e_op     = top_op;
                                e_pay    = top_pay;
                                e_last   = !(has_sec && !sec_lpar);
                                cmd      = SH_POP;
                                cnt_next = cnt_reg - CW'(1);
                                done     = e_last && !has_sec;
                            end else begin
                                // Drop the matching left paren, if any
                                if (has_top) begin
                                    cmd      = SH_POP;
                                    cnt_next = cnt_reg - CW'(1);
                                end
                                done = 1'b1;
                            end
                        end
                        TK_OPER: begin
                            if (tok_op_reg > OP_LAST) begin
                                emit     = 1'b1;
                                e_kind   = RK_ERROR;
                                e_last   = 1'b1;
                                cnt_next = '0;
                                done     = 1'b1;
                            end else if (has_top && !top_lpar &&
                                         op_pops(top_op, tok_op_reg)) begin
                                // A pop leaves room, so the later push makes no result
                                emit     = 1'b1;
                                e_kind   = RK_OPER;
                                e_op     = top_op;
                                e_pay    = top_pay;
                                e_last   = !(has_sec && !sec_lpar &&
                                             op_pops(sec_op, tok_op_reg));
                                cmd      = SH_POP;
                                cnt_next = cnt_reg - CW'(1);
                            end else if (full) begin
                                emit     = 1'b1;
                                e_kind   = RK_ERROR;
                                e_last   = 1'b1;
                                cnt_next = '0;
                                done     = 1'b1;
                            end else begin
                                cmd      = SH_PUSH;
                                cnt_next = cnt_reg + CW'(1);
                                done     = 1'b1;
                            end
                        end
                        TK_END: begin
                            if (has_top) begin
                                // Flush: drop left parens, emit operators
                                if (!top_lpar) begin
                                    emit   = 1'b1;
                                    e_kind = RK_OPER;
                                    e_op   = top_op;
                                    e_pay  = top_pay;
                                end
                                cmd      = SH_POP;
                                cnt_next = cnt_reg - CW'(1);
                            end else begin
                                emit   = 1'b1;
                                e_kind = RK_END;
                                e_last = 1'b1;
                                done   = 1'b1;
                            end
                        end
                        default: begin
                            emit     = 1'b1;
                            e_kind   = RK_ERROR;
                            e_last   = 1'b1;
                            cnt_next = '0;
                            done     = 1'b1;
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (done) begin
            state_next = ST_IDLE;
        end

        // Output register: load on emit, otherwise drain on transfer
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_op_next    = m_op_reg;
        m_pay_next   = m_pay_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_kind_next  = e_kind;
            m_op_next    = e_op;
            m_pay_next   = e_pay;
            m_last_next  = e_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            tok_kind_reg <= tok_kind_next;
            tok_op_reg   <= tok_op_next;
            tok_pay_reg  <= tok_pay_next;
            m_kind_reg   <= m_kind_next;
            m_op_reg     <= m_op_next;
            m_pay_reg    <= m_pay_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_out_kind    = m_kind_reg;
    assign m_out_op_code = m_op_reg;
    assign m_out_payload = m_pay_reg;
    assign m_last        = m_last_reg;

endmodule

// ----- hdl/ifp_cell.sv -----
// One entry of the shifting operator stack: holds {lparen, op code, payload}.
// Depends on ifp_pkg for the shift command type.
module ifp_cell #(
    parameter int ENTRY_BITS = 21
) (
    input  logic                   aclk,
    input  ifp_pkg::shift_cmd_t    cmd,
    input  logic [ENTRY_BITS-1:0]  from_above,
    input  logic [ENTRY_BITS-1:0]  from_below,
    output logic [ENTRY_BITS-1:0]  entry
);
    import ifp_pkg::*;

    logic [ENTRY_BITS-1:0] entry_reg;
    logic [ENTRY_BITS-1:0] entry_next;

    always_comb begin
        case (cmd)
            SH_PUSH: entry_next = from_above;
            SH_POP:  entry_next = from_below;
            default: entry_next = entry_reg;
        endcase
    end

    // Payload storage: no reset, contents above the fill count are never read
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- tb/sv/tb_infix_to_postfix_converter_top.sv -----
// Self-checking testbench for infix_to_postfix_converter_top (shunting-yard converter).
// Depends on ifp_pkg for token and result codes; drives random stalls on both channels and
// compares every postfix transfer against a cycle-free operator-stack predictor.
module tb_infix_to_postfix_converter_top;
    import ifp_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int PAY_W = PAYLOAD_BITS_DEF;
    localparam int RANDOM_TOKENS = 450;

    // Operator codes, same encoding on both channels
    localparam logic [3:0] OPC_ADD        = 4'd0;
    localparam logic [3:0] OPC_SUB        = 4'd1;
    localparam logic [3:0] OPC_MUL        = 4'd2;
    localparam logic [3:0] OPC_DIV        = 4'd3;
    localparam logic [3:0] OPC_POW        = 4'd4;
    localparam logic [3:0] OPC_UPLUS      = 4'd5;
    localparam logic [3:0] OPC_UMINUS     = 4'd6;
    localparam logic [3:0] OPC_SPECIAL_FN = 4'd7;
    localparam logic [3:0] OPC_NAMED_FN   = 4'd8;
    localparam logic [3:0] OPC_MAX        = 4'd15;

    // Token kinds past TK_END are all rejected
    localparam logic [2:0] TK_BAD_LO = 3'd5;
    localparam logic [2:0] TK_BAD_MID = 3'd6;
    localparam logic [2:0] TK_BAD_HI = 3'd7;

    typedef struct {
        logic [2:0]       kind;
        logic [3:0]       op;
        logic [PAY_W-1:0] pay;
        int unsigned      gap;    // idle cycles before this token is offered
        bit               drain;  // hold the token until every result is back
    } token_t;

    typedef struct {
        logic [1:0]       kind;
        logic [3:0]       op;
        logic [PAY_W-1:0] pay;
        logic             fin;
    } result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [2:0]       s_token_kind = TK_OPERAND;
    logic [3:0]       s_op_code = OPC_ADD;
    logic [PAY_W-1:0] s_payload = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_out_kind;
    logic [3:0]       m_out_op_code;
    logic [PAY_W-1:0] m_out_payload;
    logic             m_last;

    infix_to_postfix_converter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_token_kind  (s_token_kind),
        .s_op_code     (s_op_code),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_out_op_code (m_out_op_code),
        .m_out_payload (m_out_payload),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Tokens waiting to be offered, and postfix results still owed by the block
    token_t  pending_tokens[$];
    result_t postfix_q[$];
    result_t step_res[$];

    // Predictor copy of the operator stack
    bit               stk_lparen[DEPTH];
    logic [3:0]       stk_op[DEPTH];
    logic [PAY_W-1:0] stk_pay[DEPTH];
    int               stk_cnt = 0;
    int               deepest = 0;

    int mismatches = 0;
    int n_queued = 0;
    int tokens_sent = 0;
    int results_seen = 0;
    int kind_sent[8];
    int kind_seen[4];
    bit gen_calm = 1'b0;
    bit drain_next = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic result_t make_result(input logic [1:0] k, input logic [3:0] o,
                                            input logic [PAY_W-1:0] p);
        result_t r;
        r.kind = k;
        r.op   = o;
        r.pay  = p;
        r.fin  = 1'b0;
        return r;
    endfunction

    function automatic int bind_level(input logic [3:0] op);
        case (op)
            OPC_ADD, OPC_SUB:              return 1;
            OPC_MUL, OPC_DIV:              return 5;
            OPC_UPLUS, OPC_UMINUS:         return 10;
            OPC_POW:                       return 15;
            default:                       return 20;
        endcase
    endfunction

    // A stacked operator leaves when it binds tighter, or equally with a
    // left-associative newcomer.
    function automatic bit leaves_before(input logic [3:0] top_op, input logic [3:0] in_op);
        int tp;
        int ip;
        tp = bind_level(top_op);
        ip = bind_level(in_op);
        return (tp > ip) || ((tp == ip) && (in_op <= OPC_DIV));
    endfunction

    task automatic pop_operator();
        stk_cnt--;
        step_res.insert(step_res.size(), make_result(RK_OPER, stk_op[stk_cnt], stk_pay[stk_cnt]));
    endtask

    task automatic raise_error();
        stk_cnt = 0;
        step_res.insert(step_res.size(), make_result(RK_ERROR, OP_NONE, '0));
    endtask

    task automatic push_entry(input bit lp, input logic [3:0] op, input logic [PAY_W-1:0] pay);
        if (stk_cnt >= DEPTH) begin
            raise_error();
        end else begin
            stk_lparen[stk_cnt] = lp;
            stk_op[stk_cnt]     = op;
            stk_pay[stk_cnt]    = pay;
            stk_cnt++;
            if (stk_cnt > deepest)
                deepest = stk_cnt;
        end
    endtask

    // Work out the postfix results of one accepted token and queue them
    task automatic shunt_token(input logic [2:0] kind, input logic [3:0] op,
                               input logic [PAY_W-1:0] pay);
        bit stop;
        step_res.delete();
        case (kind)
            TK_OPERAND: begin
                step_res.insert(step_res.size(), make_result(RK_OPERAND, OP_NONE, pay));
            end
            TK_LPAREN: begin
                push_entry(1'b1, OP_NONE, pay);
            end
            TK_RPAREN: begin
                while (stk_cnt > 0 && !stk_lparen[stk_cnt-1])
                    pop_operator();
                // discard the matching left paren, if any
                if (stk_cnt > 0)
                    stk_cnt--;
            end
            TK_OPER: begin
                if (op > OPC_NAMED_FN) begin
                    raise_error();
                end else begin
                    stop = 1'b0;
                    while (!stop && stk_cnt > 0 && !stk_lparen[stk_cnt-1]) begin
                        if (leaves_before(stk_op[stk_cnt-1], op))
                            pop_operator();
                        else
                            stop = 1'b1;
                    end
                    push_entry(1'b0, op, pay);
                end
            end
            TK_END: begin
                while (stk_cnt > 0) begin
                    if (stk_lparen[stk_cnt-1])
                        stk_cnt--;
                    else
                        pop_operator();
                end
                step_res.insert(step_res.size(), make_result(RK_END, OP_NONE, '0));
            end
            default: begin
                raise_error();
            end
        endcase
        if (step_res.size() > 0)
            step_res[step_res.size()-1].fin = 1'b1;
        foreach (step_res[i])
            postfix_q.insert(postfix_q.size(), step_res[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic logic [PAY_W-1:0] any_pay();
        return PAY_W'($urandom);
    endfunction

    function automatic logic [3:0] any_op();
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic queue_token(input logic [2:0] kind, input logic [3:0] op,
                               input logic [PAY_W-1:0] pay);
        token_t t;
        t.kind  = kind;
        t.op    = op;
        t.pay   = pay;
        t.gap   = gen_calm ? 0 : $urandom_range(0, 8);
        t.drain = drain_next;
        drain_next = 1'b0;
        pending_tokens.insert(pending_tokens.size(), t);
        n_queued++;
    endtask

    // Well-formed expression with random content; without the end token and
    // with stray right parens it turns into a broken one.
    task automatic add_expression(input int max_len, input bit with_end);
        int depth;
        int n;
        int r;
        bit want_operand;
        bit done;
        depth = 0;
        n = 0;
        want_operand = 1'b1;
        done = 1'b0;
        while (!done) begin
            r = $urandom_range(0, 9);
            if (want_operand) begin
                if (n >= max_len || r < 5) begin
                    queue_token(TK_OPERAND, any_op(), any_pay());
                    want_operand = 1'b0;
                end else if (r < 8) begin
                    queue_token(TK_LPAREN, any_op(), any_pay());
                    depth++;
                end else begin
                    queue_token(TK_OPER, 4'($urandom_range(OPC_UPLUS, OPC_NAMED_FN)), any_pay());
                end
            end else if (n >= max_len) begin
                repeat (depth) queue_token(TK_RPAREN, any_op(), any_pay());
                done = 1'b1;
            end else if (r < 6) begin
                queue_token(TK_OPER, 4'($urandom_range(OPC_ADD, OPC_POW)), any_pay());
                want_operand = 1'b1;
            end else if (depth > 0) begin
                queue_token(TK_RPAREN, any_op(), any_pay());
                depth--;
            end else if (!with_end && r == 9) begin
                queue_token(TK_RPAREN, any_op(), any_pay());
            end else begin
                done = 1'b1;
            end
            n++;
        end
        if (with_end)
            queue_token(TK_END, any_op(), any_pay());
    endtask

    // Sequences that fill the stack: a full flush, an overflowing paren and an
    // overflowing operator push.
    task automatic add_deep(input int variant);
        queue_token(TK_END, any_op(), any_pay());
        if (variant == 1) begin
            repeat (DEPTH + 1) queue_token(TK_LPAREN, any_op(), any_pay());
        end else begin
            queue_token(TK_OPERAND, any_op(), any_pay());
            repeat (DEPTH) begin
                queue_token(TK_OPER, OPC_POW, any_pay());
                queue_token(TK_OPERAND, any_op(), any_pay());
            end
            if (variant == 2)
                queue_token(TK_OPER, OPC_POW, any_pay());
        end
        queue_token(TK_END, any_op(), any_pay());
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending tokens, honor per-token gaps and drain holds
    // ------------------------------------------------------------------
    int unsigned idle_cnt = 0;

    always @(posedge aclk) begin : drive_tokens
        bit     vld;
        token_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            idle_cnt = 0;
        end else begin
            vld = s_valid;
            if (s_valid && s_ready) begin
                // predict from the payload that was just transferred
                shunt_token(s_token_kind, s_op_code, s_payload);
                tokens_sent++;
                kind_sent[s_token_kind]++;
                vld = 1'b0;
            end
            if (!vld && pending_tokens.size() > 0) begin
                if (idle_cnt < pending_tokens[0].gap) begin
                    idle_cnt++;
                end else if (!pending_tokens[0].drain || postfix_q.size() == 0) begin
                    // offer the next token; with a zero gap valid simply stays high
                    nxt = pending_tokens.pop_front();
                    s_token_kind <= nxt.kind;
                    s_op_code    <= nxt.op;
                    s_payload    <= nxt.pay;
                    vld = 1'b1;
                    idle_cnt = 0;
                end
            end
            s_valid <= vld;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, compare each transfer with the oldest
    // expectation
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    bit          rx_calm = 1'b0;

    always @(posedge aclk) begin : check_results
        result_t want;
        bit      rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            rdy = m_ready;
            if (m_valid && m_ready) begin
                results_seen++;
                kind_seen[m_out_kind]++;
                if (postfix_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d op %0d pay %h last %0b",
                                              m_out_kind, m_out_op_code, m_out_payload, m_last));
                end else begin
                    want = postfix_q.pop_front();
                    if (m_out_kind !== want.kind || m_out_op_code !== want.op ||
                        m_out_payload !== want.pay || m_last !== want.fin)
                        report_mismatch($sformatf(
                            "result %0d: got kind %0d op %0d pay %h last %0b, want %0d %0d %h %0b",
                            results_seen, m_out_kind, m_out_op_code, m_out_payload, m_last,
                            want.kind, want.op, want.pay, want.fin));
                end
                // switch between calm and stalling stretches now and then
                if (results_seen % 50 == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
                stall_left = rx_calm ? 0 : $urandom_range(0, 8);
                rdy = (stall_left == 0);
            end else if (!m_ready) begin
                if (stall_left > 0)
                    stall_left--;
                if (stall_left == 0)
                    rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int rand_start;
        int pick;
        int len;

        // Directed: field extremes, every operator and the special cases
        queue_token(TK_OPERAND, OPC_MAX, '1);         // operand op code is ignored
        queue_token(TK_OPERAND, OPC_ADD, '0);
        queue_token(TK_RPAREN, OPC_ADD, '0);          // right paren on empty stack: silent
        queue_token(TK_LPAREN, OPC_MAX, '1);
        queue_token(TK_OPER, OPC_NAMED_FN, '1);
        queue_token(TK_OPER, OPC_SPECIAL_FN, 16'h1234); // equal level, right assoc: no pop
        queue_token(TK_OPER, OPC_UMINUS, 16'h00ff);     // pops both functions
        queue_token(TK_OPER, OPC_UPLUS, '0);
        queue_token(TK_OPERAND, OPC_ADD, any_pay());
        queue_token(TK_OPER, OPC_POW, any_pay());
        queue_token(TK_OPERAND, OPC_ADD, any_pay());
        queue_token(TK_OPER, OPC_DIV, any_pay());     // pops pow and both unaries
        queue_token(TK_OPER, OPC_MUL, any_pay());
        queue_token(TK_OPER, OPC_SUB, any_pay());
        queue_token(TK_OPER, OPC_ADD, any_pay());
        queue_token(TK_RPAREN, OPC_ADD, any_pay());   // matched: pops add, drops paren
        queue_token(TK_LPAREN, OPC_ADD, any_pay());
        queue_token(TK_OPER, OPC_POW, any_pay());
        queue_token(TK_LPAREN, OPC_ADD, any_pay());
        queue_token(TK_END, OPC_MAX, '1);             // left parens dropped in the flush
        queue_token(TK_OPER, 4'd9, any_pay());        // lowest invalid op code
        queue_token(TK_LPAREN, OPC_ADD, any_pay());
        queue_token(TK_OPER, OPC_MAX, any_pay());     // invalid op code clears the stack
        queue_token(TK_BAD_LO, OPC_ADD, any_pay());
        queue_token(TK_BAD_MID, OPC_MAX, '1);
        queue_token(TK_OPER, OPC_ADD, any_pay());
        queue_token(TK_BAD_HI, OPC_ADD, any_pay());   // invalid kind with a stacked operator
        queue_token(TK_OPER, OPC_SUB, any_pay());
        queue_token(TK_RPAREN, OPC_ADD, any_pay());   // unmatched: empties the stack
        queue_token(TK_END, OPC_ADD, '0);

        // Hold the first deep-stack token until the directed results have drained
        drain_next = 1'b1;
        rand_start = n_queued;
        for (int v = 0; v < 3; v++)
            add_deep(v);

        while (n_queued - rand_start < RANDOM_TOKENS) begin
            if ($urandom_range(0, 9) == 0)
                gen_calm = !gen_calm;
            if ($urandom_range(0, 49) == 0)
                drain_next = 1'b1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                add_expression(len, 1'b1);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4))
                    queue_token(3'($urandom_range(0, 7)), any_op(), any_pay());
            end else if (pick < 98) begin
                add_expression(len, 1'b0);
            end else begin
                add_deep($urandom_range(0, 2));
            end
        end

        // Release reset
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every token to go out and every result to come back
        while (pending_tokens.size() != 0 || s_valid || postfix_q.size() != 0)
            @(posedge aclk);
        // Let any stray late result show up
        repeat (40) @(posedge aclk);

        $display("Sent %0d tokens: %0d operands, %0d parens, %0d operators, %0d ends, %0d bad kinds",
                 tokens_sent, kind_sent[TK_OPERAND], kind_sent[TK_LPAREN] + kind_sent[TK_RPAREN],
                 kind_sent[TK_OPER], kind_sent[TK_END],
                 kind_sent[TK_BAD_LO] + kind_sent[TK_BAD_MID] + kind_sent[TK_BAD_HI]);
        $display("Checked %0d results (%0d operators, %0d ends, %0d errors), stack depth up to %0d",
                 results_seen, kind_seen[RK_OPER], kind_seen[RK_END], kind_seen[RK_ERROR],
                 deepest);
        if (mismatches == 0) begin
            $display("tb_infix_to_postfix_converter_top passed");
        end else begin
            $display("tb_infix_to_postfix_converter_top failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("Timeout with %0d tokens pending and %0d results owed",
                 pending_tokens.size(), postfix_q.size());
        $display("tb_infix_to_postfix_converter_top failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ifp_pkg.sv
hdl/ifp_cell.sv
hdl/infix_to_postfix_converter_top.sv
tb/sv/tb_infix_to_postfix_converter_top.sv
